@@ rtl/core/rbb_pkg.sv @@
`timescale 1ns / 1ps

package rbb_pkg;

  localparam int NumCh   = 4;
  localparam int ChW     = 8;
  // three 8-bit samples of one column, then three column sums
  localparam int ColSumW = 10;
  localparam int WinSumW = 12;

  localparam int CfgW    = 10;
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgIdxWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxHeight = 2'd1;

  // floor(x / 9) == (x * 3641) >> 15 for every x below 32768
  localparam int Div9Mul   = 3641;
  localparam int Div9Shift = 15;
  localparam int ProdW     = 24;

  localparam int FifoDepth = 8;
  localparam int FifoPtrW  = 3;
  localparam int FifoCntW  = 4;
  localparam int PendW     = 5;

  // channel 0 red in bits 7..0 up to channel 3 alpha in bits 31..24
  typedef logic [NumCh-1:0][ChW-1:0]     pixel_t;
  typedef logic [NumCh-1:0][ColSumW-1:0] col_sum_t;
  typedef logic [NumCh-1:0][WinSumW-1:0] win_sum_t;

  typedef struct packed {
    pixel_t prev;
    pixel_t bprev;
  } line_pair_t;

  typedef struct packed {
    logic is_flush;
    logic first;
    logic last;
    logic use_b;
    logic row_ge1;
    logic save_c0;
    logic a_en;
    logic b_en;
    logic frame_end;
  } item_ctrl_t;

  typedef struct packed {
    logic a_valid;
    logic b_valid;
    logic frame_end;
  } win_flags_t;

  typedef struct packed {
    logic   frame_end;
    pixel_t pix;
  } result_t;

endpackage

@@ rtl/core/rbb_line_mem.sv @@
`timescale 1ns / 1ps

module rbb_line_mem #(
  parameter int Depth = 512,
  parameter int AddrW = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  input  logic                wr_en_i,
  input  rbb_pkg::line_pair_t wr_data_i,
  output rbb_pkg::line_pair_t rd_data_o
);
  import rbb_pkg::*;

  line_pair_t mem [Depth];
  line_pair_t rd_q;
  line_pair_t fwd_data_q;
  logic       fwd_hit_q;
  logic [AddrW-1:0] addr_q;

  // write back at the address read in the previous cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_q] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q   <= mem[rd_addr_i];
      addr_q <= rd_addr_i;
    end
    fwd_data_q <= wr_data_i;
  end

  // read of the entry being written: hand over the new word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_hit_q <= wr_en_i && (rd_addr_i == addr_q);
    end
  end

  assign rd_data_o = fwd_hit_q ? fwd_data_q : rd_q;

endmodule

@@ rtl/core/rbb_window.sv @@
`timescale 1ns / 1ps

module rbb_window (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  rbb_pkg::item_ctrl_t ctrl_i,
  input  rbb_pkg::pixel_t     pix_i,
  input  rbb_pkg::line_pair_t rd_data_i,
  output logic                wr_en_o,
  output rbb_pkg::line_pair_t wr_data_o,
  output rbb_pkg::win_flags_t flags_o,
  output rbb_pkg::win_sum_t   a_sum_o,
  output rbb_pkg::win_sum_t   b_sum_o
);
  import rbb_pkg::*;

  col_sum_t   s0_q, s1_q, c0_q;
  col_sum_t   cs, c0_d, base, left, mid;
  win_sum_t   a_sum_d, b_sum_d;
  win_sum_t   a_sum_q, b_sum_q;
  win_flags_t flags_q;
  pixel_t     p, b;

  assign p = rd_data_i.prev;
  assign b = rd_data_i.bprev;

  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      cs[ch] = ColSumW'(ctrl_i.use_b ? b[ch] : p[ch]) + ColSumW'(p[ch])
             + ColSumW'(ctrl_i.is_flush ? p[ch] : pix_i[ch]);
      c0_d[ch] = ColSumW'(ctrl_i.row_ge1 ? p[ch] : pix_i[ch]) + ColSumW'(pix_i[ch])
               + ColSumW'(pix_i[ch]);
    end
    // first column: left and centre replicate the edge column
    base = ctrl_i.is_flush ? c0_q : cs;
    left = ctrl_i.first ? base : s0_q;
    mid  = ctrl_i.first ? base : s1_q;
    for (int ch = 0; ch < NumCh; ch++) begin
      a_sum_d[ch] = WinSumW'(left[ch]) + WinSumW'(mid[ch]) + WinSumW'(cs[ch]);
      b_sum_d[ch] = WinSumW'(s1_q[ch]) + WinSumW'(cs[ch]) + WinSumW'(cs[ch]);
    end
  end

  assign wr_en_o         = valid_i && !ctrl_i.is_flush;
  assign wr_data_o.prev  = pix_i;
  assign wr_data_o.bprev = p;

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      s0_q <= mid;
      s1_q <= cs;
      if (ctrl_i.save_c0 && !ctrl_i.is_flush) begin
        c0_q <= c0_d;
      end
    end
    a_sum_q <= a_sum_d;
    b_sum_q <= b_sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q.a_valid   <= valid_i && ctrl_i.a_en;
      flags_q.b_valid   <= valid_i && ctrl_i.b_en;
      flags_q.frame_end <= ctrl_i.frame_end;
    end
  end

  assign flags_o = flags_q;
  assign a_sum_o = a_sum_q;
  assign b_sum_o = b_sum_q;

endmodule

@@ rtl/core/rbb_div9.sv @@
`timescale 1ns / 1ps

module rbb_div9 (
  input  rbb_pkg::win_flags_t flags_i,
  input  rbb_pkg::win_sum_t   a_sum_i,
  input  rbb_pkg::win_sum_t   b_sum_i,
  output logic                push_a_o,
  output logic                push_b_o,
  output rbb_pkg::result_t    res_a_o,
  output rbb_pkg::result_t    res_b_o
);
  import rbb_pkg::*;

  logic [ProdW-1:0] prod_a [NumCh];
  logic [ProdW-1:0] prod_b [NumCh];

  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      prod_a[ch] = ProdW'(a_sum_i[ch]) * ProdW'(Div9Mul);
      prod_b[ch] = ProdW'(b_sum_i[ch]) * ProdW'(Div9Mul);
      res_a_o.pix[ch] = prod_a[ch][Div9Shift +: ChW];
      res_b_o.pix[ch] = prod_b[ch][Div9Shift +: ChW];
    end
    res_a_o.frame_end = flags_i.frame_end;
    res_b_o.frame_end = 1'b0;
  end

  assign push_a_o = flags_i.a_valid;
  assign push_b_o = flags_i.b_valid;

endmodule

@@ rtl/core/rbb_out_fifo.sv @@
`timescale 1ns / 1ps

module rbb_out_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_a_i,
  input  rbb_pkg::result_t              data_a_i,
  input  logic                          push_b_i,
  input  rbb_pkg::result_t              data_b_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rbb_pkg::result_t              out_data_o,
  output logic [rbb_pkg::FifoCntW-1:0]  count_o
);
  import rbb_pkg::*;

  result_t               mem [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]   count_q, count_d, push_n;
  logic                  pop;

  assign pop    = out_valid_o && out_ready_i;
  assign push_n = FifoCntW'(push_a_i) + FifoCntW'(push_b_i);

  always_comb begin
    wr_ptr_d = wr_ptr_q + FifoPtrW'(push_n);
    rd_ptr_d = rd_ptr_q + FifoPtrW'(pop);
    count_d  = count_q + push_n - FifoCntW'(pop);
  end

  // second beat of a row end lands right after the first
  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      mem[wr_ptr_q] <= data_a_i;
    end
    if (push_b_i) begin
      mem[wr_ptr_q + FifoPtrW'(1)] <= data_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem[rd_ptr_q];
  assign count_o     = count_q;

endmodule

@@ rtl/core/rgba_box_blur_3x3_top.sv @@
`timescale 1ns / 1ps

// 3x3 box blur over an RGBA pixel stream, edge pixels replicated past the border.
// Input channel: one beat per pixel in raster order (flush_i low), then, once the
// frame is in, one flush beat per pixel of the last row to drain it. Pixels sent
// while draining and flushes sent while not draining are dropped.
// Output channel: one beat per filtered pixel; frame_end_o marks the last one.
// Output row r comes out while input row r+1 streams in, one pixel behind it; the
// last pixel of a row yields two beats, the first pixel of a row none.
// A beat passes the front-stage registers, the window-stage sums and the output FIFO.
// Throughput: one input beat per cycle while in_ready_o is high, set by the single
// read-modify-write port of the line memory (one read and one write-back per pixel).
// The receiver may stall at will: results queue in an 8-entry output FIFO, and
// in_ready_o drops while queued plus in-flight results leave no room for two more.
// Configuration: cfg_we_i writes image width (index 0) or height (index 1), clamped
// to 1..max; any such write restarts the frame. Write only while the block is idle.
// Reset: frame restarts, width and height return to 512 (or the maximum, if less);
// the line memory is not cleared, its stale words never reach an output.
module rgba_box_blur_3x3_top #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rbb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rbb_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [rbb_pkg::ChW-1:0]      red_in_i,
  input  logic [rbb_pkg::ChW-1:0]      green_in_i,
  input  logic [rbb_pkg::ChW-1:0]      blue_in_i,
  input  logic [rbb_pkg::ChW-1:0]      alpha_in_i,
  input  logic                         flush_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rbb_pkg::ChW-1:0]      red_out_o,
  output logic [rbb_pkg::ChW-1:0]      green_out_o,
  output logic [rbb_pkg::ChW-1:0]      blue_out_o,
  output logic [rbb_pkg::ChW-1:0]      alpha_out_o,
  output logic                         frame_end_o
);
  import rbb_pkg::*;

  localparam int AddrW   = $clog2(MAX_WIDTH);
  localparam int CfgTop  = (2 ** CfgW) - 1;
  localparam int WClip   = (MAX_WIDTH > CfgTop) ? CfgTop : MAX_WIDTH;
  localparam int HClip   = (MAX_HEIGHT > CfgTop) ? CfgTop : MAX_HEIGHT;
  localparam logic [CfgW-1:0] WMax   = CfgW'(WClip);
  localparam logic [CfgW-1:0] HMax   = CfgW'(HClip);
  localparam logic [CfgW-1:0] WReset = CfgW'((WClip > 512) ? 512 : WClip);
  localparam logic [CfgW-1:0] HReset = CfgW'((HClip > 512) ? 512 : HClip);

  function automatic logic [CfgW-1:0] clamp_reg(logic [CfgW-1:0] v, logic [CfgW-1:0] maxv);
    logic [CfgW-1:0] r;
    r = v;
    if (v == '0) begin
      r = CfgW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

  // frame position and settings
  logic [CfgW-1:0] width_q, width_d, height_q, height_d;
  logic [CfgW-1:0] col_q, col_d, row_q, row_d, x_q, x_d;
  logic            drain_q, drain_d;
  logic            restart;

  // front stage: item entering the window stage
  logic            s1_valid_q;
  item_ctrl_t      s1_ctrl_q, ctrl;
  pixel_t          s1_pix_q, pix_in;

  logic            accept, take;
  logic            col_last, row_last, x_last;
  logic [AddrW-1:0] rd_addr;

  line_pair_t      rd_data, wr_data;
  logic            wr_en;
  win_flags_t      s2_flags;
  win_sum_t        a_sum, b_sum;
  logic            push_a, push_b;
  result_t         res_a, res_b, out_data;
  logic [FifoCntW-1:0] fifo_cnt;
  logic [PendW-1:0]    pend;

  assign pix_in = {alpha_in_i, blue_in_i, green_in_i, red_in_i};

  assign col_last = (col_q == width_q - CfgW'(1));
  assign row_last = (row_q == height_q - CfgW'(1));
  assign x_last   = (x_q == width_q - CfgW'(1));

  assign accept = in_valid_i && in_ready_o;
  // drop pixels while draining and flushes while streaming
  assign take   = accept && (flush_i ? drain_q : !drain_q);

  // decode the item: which results it yields and how its columns are formed
  always_comb begin
    ctrl    = '0;
    rd_addr = AddrW'(col_q);
    if (flush_i) begin
      ctrl.is_flush  = 1'b1;
      ctrl.first     = (x_q == '0);
      ctrl.last      = x_last;
      ctrl.use_b     = (height_q != CfgW'(1));
      ctrl.a_en      = 1'b1;
      ctrl.frame_end = x_last;
      // fetch the right-hand column ahead, clamped at the right edge
      rd_addr        = x_last ? AddrW'(x_q) : AddrW'(x_q + CfgW'(1));
    end else begin
      ctrl.first     = (col_q == '0);
      ctrl.last      = col_last;
      ctrl.row_ge1   = (row_q != '0);
      ctrl.use_b     = (row_q[CfgW-1:1] != '0);
      ctrl.save_c0   = row_last && (col_q == '0);
      ctrl.a_en      = (row_q != '0) && ((col_q != '0) || col_last);
      ctrl.b_en      = (row_q != '0) && col_last && (col_q != '0);
    end
  end

  // next frame position; a width/height write or the final flush restarts the frame
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    x_d      = x_q;
    drain_d  = drain_q;
    restart  = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxWidth: begin
          width_d = clamp_reg(cfg_data_i, WMax);
          restart = 1'b1;
        end
        CfgIdxHeight: begin
          height_d = clamp_reg(cfg_data_i, HMax);
          restart  = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (take) begin
      if (flush_i) begin
        x_d     = x_q + CfgW'(1);
        restart = x_last;
      end else if (col_last) begin
        col_d = '0;
        row_d = row_q + CfgW'(1);
        if (row_last) begin
          drain_d = 1'b1;
          x_d     = '0;
        end
      end else begin
        col_d = col_q + CfgW'(1);
      end
    end
    if (restart) begin
      col_d   = '0;
      row_d   = '0;
      x_d     = '0;
      drain_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WReset;
      height_q   <= HReset;
      col_q      <= '0;
      row_q      <= '0;
      x_q        <= '0;
      drain_q    <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      col_q      <= col_d;
      row_q      <= row_d;
      x_q        <= x_d;
      drain_q    <= drain_d;
      s1_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_ctrl_q <= ctrl;
      s1_pix_q  <= pix_in;
    end
  end

  // hold off input while the FIFO could not absorb two more results
  always_comb begin
    pend = PendW'(fifo_cnt) + PendW'(s2_flags.a_valid) + PendW'(s2_flags.b_valid);
    if (s1_valid_q) begin
      pend = pend + PendW'(s1_ctrl_q.a_en) + PendW'(s1_ctrl_q.b_en);
    end
  end

  assign in_ready_o = (pend <= PendW'(FifoDepth - 2));

  rbb_line_mem #(
    .Depth (MAX_WIDTH),
    .AddrW (AddrW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (take),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  rbb_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid_q),
    .ctrl_i    (s1_ctrl_q),
    .pix_i     (s1_pix_q),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_data_o (wr_data),
    .flags_o   (s2_flags),
    .a_sum_o   (a_sum),
    .b_sum_o   (b_sum)
  );

  rbb_div9 u_div9 (
    .flags_i  (s2_flags),
    .a_sum_i  (a_sum),
    .b_sum_i  (b_sum),
    .push_a_o (push_a),
    .push_b_o (push_b),
    .res_a_o  (res_a),
    .res_b_o  (res_b)
  );

  rbb_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_a_i    (push_a),
    .data_a_i    (res_a),
    .push_b_i    (push_b),
    .data_b_i    (res_b),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data),
    .count_o     (fifo_cnt)
  );

  assign red_out_o   = out_data.pix[0];
  assign green_out_o = out_data.pix[1];
  assign blue_out_o  = out_data.pix[2];
  assign alpha_out_o = out_data.pix[3];
  assign frame_end_o = out_data.frame_end;

endmodule
